// File: rtl/cst_pkg.sv
`default_nettype none

package cst_pkg;

	// Sizes of the function table and of the call stack.
	localparam int MAX_FUNCTIONS = 256;
	localparam int STACK_DEPTH   = 1024;

	// Derived widths.
	localparam int FUNC_AW  = $clog2(MAX_FUNCTIONS);
	localparam int COUNT_W  = $clog2(MAX_FUNCTIONS + 1);
	localparam int FRAME_AW = $clog2(STACK_DEPTH);
	localparam int DEPTH_W  = $clog2(STACK_DEPTH + 1);

	// Field widths of the stream words.
	localparam int ADDR_W    = 32;
	localparam int FIDX_W    = 8;
	localparam int IN_DATA_W = 136;
	localparam int OUT_DATA_W = 56;

	// Function index that marks an unknown function.
	localparam logic [COUNT_W-1:0] UNKNOWN_FUNC = COUNT_W'(MAX_FUNCTIONS);
	localparam logic [DEPTH_W-1:0] STACK_FULL   = DEPTH_W'(STACK_DEPTH);
	localparam logic [ADDR_W-1:0]  RET_OFFSET   = ADDR_W'(4);

	// Table entry holds start in the low half and size in the high half.
	localparam int TBL_W   = 2 * ADDR_W;
	// Frame holds the function index above the return address.
	localparam int FRAME_W = COUNT_W + ADDR_W;

	// Item kinds carried on the input tuser.
	typedef enum logic [1:0] {
		KIND_LOAD = 2'd0,
		KIND_CALL = 2'd1,
		KIND_RET  = 2'd2
	} kind_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CALL_DONE,
		ST_POP,
		ST_RESULT
	} state_t;

endpackage

`default_nettype wire

// File: rtl/cst_ram.sv
`default_nettype none

module cst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] addr,
	input  wire  [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Single port, write or registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else begin
			rdata <= mem[addr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/call_stack_tracer_with_symbol_lookup_unit.sv
// Call stack tracer with function lookup.
// Input words arrive on the s_axis channel; tuser carries the kind (load table
// entry, call, return) and tdata the entry and instruction fields. Every
// accepted word produces exactly one result word on the m_axis channel.
// The cfg channel writes the number of table entries in use; it is always
// ready, and the user must write it only while the block is idle; the block
// itself does not enforce this. A load goes from idle to the result state. A
// return with frames on the stack goes through the pop state to the result
// state. A call with entries in use scans the function table in its RAM, one
// entry per cycle through the single read port, first for an exact start
// match and then for a range match, and then goes through the call-done state
// to the result state. Only one word is in work at a time; the next word is
// taken as soon as the result has moved to the output register.
// Reset clears the stack depth, the entry count and all handshake state; the
// table and frame RAMs are not cleared and must be loaded before lookups.
// When the receiver stalls, the result waits in the output register, one more
// result can wait in the block, and then the input stops being ready.
`default_nettype none

module call_stack_tracer_with_symbol_lookup_unit (
	input  wire         clk,
	input  wire         arst_n,
	// Input words.
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata: entry_index[7:0], entry_start[39:8], entry_size[71:40],
	// pc[103:72], target[135:104]
	input  wire [135:0] s_axis_tdata,
	// tuser: kind[1:0]
	input  wire [1:0]   s_axis_tuser,
	// Result words.
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	// tdata: depth[10:0], func_found[11], func_index[19:12],
	// ret_addr[51:20], overflow[52], underflow[53], zero[55:54]
	output logic [55:0] m_axis_tdata,
	// Register write channel.
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire [8:0]   cfg_data
);

	cst_pkg::state_t state_q, state_d;

	// Input fields.
	logic [7:0]  entry_index;
	logic [31:0] entry_start, entry_size, in_pc, in_target;
	cst_pkg::kind_t kind;

	assign entry_index = s_axis_tdata[7:0];
	assign entry_start = s_axis_tdata[39:8];
	assign entry_size  = s_axis_tdata[71:40];
	assign in_pc       = s_axis_tdata[103:72];
	assign in_target   = s_axis_tdata[135:104];
	assign kind        = cst_pkg::kind_t'(s_axis_tuser);

	// Control and work registers.
	logic [cst_pkg::COUNT_W-1:0] count_q, used_q, addr_q, hit_q;
	logic [cst_pkg::DEPTH_W-1:0] depth_q;
	logic [cst_pkg::ADDR_W-1:0]  pc_q, target_q;
	logic                        pass_q;
	logic                        vld_s1;
	logic [cst_pkg::FUNC_AW-1:0] idx_s1;

	// Pending result.
	logic [cst_pkg::DEPTH_W-1:0] res_depth_q;
	logic                        res_found_q, res_ovf_q, res_unf_q;
	logic [cst_pkg::FIDX_W-1:0]  res_fidx_q;
	logic [cst_pkg::ADDR_W-1:0]  res_raddr_q;

	// RAM ports.
	logic                         tbl_we;
	logic [cst_pkg::FUNC_AW-1:0]  tbl_addr;
	logic [cst_pkg::TBL_W-1:0]    tbl_wdata, tbl_rdata;
	logic                         frm_we;
	logic [cst_pkg::FRAME_AW-1:0] frm_addr;
	logic [cst_pkg::FRAME_W-1:0]  frm_wdata, frm_rdata;

	logic                        accept, out_free, issue, match, last;
	logic                        slot_ok, full;
	logic [cst_pkg::COUNT_W-1:0] used_now, frm_func;
	logic [cst_pkg::DEPTH_W-1:0] depth_dec;
	logic [cst_pkg::ADDR_W-1:0]  tbl_start, tbl_size, tbl_diff;

	cst_ram #(
		.WIDTH(cst_pkg::TBL_W),
		.DEPTH(cst_pkg::MAX_FUNCTIONS)
	) u_table (
		.clk  (clk),
		.we   (tbl_we),
		.addr (tbl_addr),
		.wdata(tbl_wdata),
		.rdata(tbl_rdata)
	);

	cst_ram #(
		.WIDTH(cst_pkg::FRAME_W),
		.DEPTH(cst_pkg::STACK_DEPTH)
	) u_frames (
		.clk  (clk),
		.we   (frm_we),
		.addr (frm_addr),
		.wdata(frm_wdata),
		.rdata(frm_rdata)
	);

	assign cfg_ready = 1'b1;
	assign accept    = s_axis_tvalid && s_axis_tready;
	assign out_free  = !m_axis_tvalid || m_axis_tready;
	assign used_now  = (count_q > cst_pkg::UNKNOWN_FUNC) ? cst_pkg::UNKNOWN_FUNC : count_q;
	assign slot_ok   = cst_pkg::COUNT_W'(entry_index) < cst_pkg::UNKNOWN_FUNC;
	assign depth_dec = depth_q - cst_pkg::DEPTH_W'(1);
	assign full      = depth_q >= cst_pkg::STACK_FULL;
	assign frm_func  = frm_rdata[cst_pkg::FRAME_W-1:cst_pkg::ADDR_W];

	// Compare of the table entry that was read in the previous cycle.
	assign tbl_start = tbl_rdata[cst_pkg::ADDR_W-1:0];
	assign tbl_size  = tbl_rdata[cst_pkg::TBL_W-1:cst_pkg::ADDR_W];
	assign tbl_diff  = target_q - tbl_start;
	assign match     = vld_s1 && (pass_q ? ((tbl_size != '0) && (tbl_diff < tbl_size))
	                                     : (tbl_start == target_q));
	assign last      = vld_s1 && (cst_pkg::COUNT_W'(idx_s1) == used_q - cst_pkg::COUNT_W'(1));
	assign issue     = (state_q == cst_pkg::ST_SCAN) && (addr_q < used_q) && !match;

	// Next state and RAM control.
	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		tbl_we        = 1'b0;
		tbl_addr      = addr_q[cst_pkg::FUNC_AW-1:0];
		tbl_wdata     = {entry_size, entry_start};
		frm_we        = 1'b0;
		frm_addr      = depth_q[cst_pkg::FRAME_AW-1:0];
		frm_wdata     = {hit_q, pc_q + cst_pkg::RET_OFFSET};
		case (state_q)
			cst_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					case (kind)
						cst_pkg::KIND_LOAD: begin
							tbl_we   = slot_ok;
							tbl_addr = entry_index[cst_pkg::FUNC_AW-1:0];
							state_d  = cst_pkg::ST_RESULT;
						end
						cst_pkg::KIND_CALL: begin
							state_d = (used_now == '0) ? cst_pkg::ST_CALL_DONE
							                           : cst_pkg::ST_SCAN;
						end
						cst_pkg::KIND_RET: begin
							frm_addr = depth_dec[cst_pkg::FRAME_AW-1:0];
							state_d  = (depth_q == '0) ? cst_pkg::ST_RESULT
							                           : cst_pkg::ST_POP;
						end
						default: state_d = cst_pkg::ST_RESULT;
					endcase
				end
			end
			cst_pkg::ST_SCAN: begin
				if (match || (last && pass_q)) begin
					state_d = cst_pkg::ST_CALL_DONE;
				end
			end
			cst_pkg::ST_CALL_DONE: begin
				frm_we  = !full;
				state_d = cst_pkg::ST_RESULT;
			end
			cst_pkg::ST_POP: begin
				state_d = cst_pkg::ST_RESULT;
			end
			cst_pkg::ST_RESULT: begin
				if (out_free) begin
					state_d = cst_pkg::ST_IDLE;
				end
			end
			default: state_d = cst_pkg::ST_IDLE;
		endcase
	end

	// State, depth, count and output handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= cst_pkg::ST_IDLE;
			count_q       <= '0;
			depth_q       <= '0;
			vld_s1        <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= issue;
			if (cfg_valid) begin
				count_q <= cfg_data;
			end
			if (accept && (kind == cst_pkg::KIND_RET) && (depth_q != '0)) begin
				depth_q <= depth_dec;
			end else if ((state_q == cst_pkg::ST_CALL_DONE) && !full) begin
				depth_q <= depth_q + cst_pkg::DEPTH_W'(1);
			end
			if ((state_q == cst_pkg::ST_RESULT) && out_free) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

	// Work registers and result staging.
	always_ff @(posedge clk) begin
		idx_s1 <= addr_q[cst_pkg::FUNC_AW-1:0];
		case (state_q)
			cst_pkg::ST_IDLE: begin
				pc_q        <= in_pc;
				target_q    <= in_target;
				used_q      <= used_now;
				addr_q      <= '0;
				pass_q      <= 1'b0;
				hit_q       <= cst_pkg::UNKNOWN_FUNC;
				res_depth_q <= depth_q;
				res_found_q <= 1'b0;
				res_fidx_q  <= '0;
				res_raddr_q <= '0;
				res_ovf_q   <= 1'b0;
				res_unf_q   <= (kind == cst_pkg::KIND_RET) && (depth_q == '0);
			end
			cst_pkg::ST_SCAN: begin
				if (match) begin
					hit_q <= cst_pkg::COUNT_W'(idx_s1);
				end else if (last && !pass_q) begin
					pass_q <= 1'b1;
					addr_q <= '0;
				end else if (issue) begin
					addr_q <= addr_q + cst_pkg::COUNT_W'(1);
				end
			end
			cst_pkg::ST_CALL_DONE: begin
				res_depth_q <= full ? depth_q : depth_q + cst_pkg::DEPTH_W'(1);
				res_found_q <= hit_q != cst_pkg::UNKNOWN_FUNC;
				res_fidx_q  <= (hit_q != cst_pkg::UNKNOWN_FUNC) ? hit_q[cst_pkg::FIDX_W-1:0] : '0;
				res_raddr_q <= pc_q + cst_pkg::RET_OFFSET;
				res_ovf_q   <= full;
			end
			cst_pkg::ST_POP: begin
				res_depth_q <= depth_q;
				res_found_q <= frm_func < cst_pkg::UNKNOWN_FUNC;
				res_fidx_q  <= (frm_func < cst_pkg::UNKNOWN_FUNC) ? frm_func[cst_pkg::FIDX_W-1:0] : '0;
				res_raddr_q <= frm_rdata[cst_pkg::ADDR_W-1:0];
			end
			default: begin
			end
		endcase
		if ((state_q == cst_pkg::ST_RESULT) && out_free) begin
			m_axis_tdata <= {2'b00, res_unf_q, res_ovf_q, res_raddr_q, res_fidx_q,
			                 res_found_q, res_depth_q};
		end
	end

	// The stack never holds more frames than it has room for.
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= cst_pkg::STACK_FULL)
		else $error("stack depth beyond capacity");

	// A compare result only shows up while a call scan is running.
	a_scan_only: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (state_q == cst_pkg::ST_SCAN || state_q == cst_pkg::ST_CALL_DONE))
		else $error("table read outside a scan");

	// A result never reports both overflow and underflow.
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[52] && m_axis_tdata[53]))
		else $error("overflow and underflow together");

	// A push only happens from a completed call and moves depth up by one.
	a_push_depth: assert property (@(posedge clk) disable iff (!arst_n)
		frm_we |=> depth_q == $past(depth_q) + cst_pkg::DEPTH_W'(1))
		else $error("push did not advance the depth");

endmodule

`default_nettype wire
